### sv/etb_pkg.sv
// ----------------------------------------------------------------------------
// etb_pkg: shared types and constants of the event timer bank
// Field widths, command and result codes, per-timer state record, sequencer
// states and the unit-to-millisecond scale table.
// ----------------------------------------------------------------------------
package etb_pkg;

  localparam int TIMER_COUNT_DEF = 8;

  localparam int CMD_W   = 3;
  localparam int IDX_W   = 3;
  localparam int VAL_W   = 32;
  localparam int UNIT_W  = 2;
  localparam int KIND_W  = 2;
  localparam int MS_W    = 48;
  localparam int SCALE_W = 16;

  // reads divide in 16-bit digits, each in a trial phase and a remainder phase
  localparam int DIG_W      = 16;
  localparam int DIV_DIGITS = MS_W / DIG_W;
  localparam int DIV_CNT_W  = $clog2(DIV_DIGITS + 1);
  // odd part of the unit scale is at most 1875
  localparam int ODD_W      = 11;
  localparam int TRIAL_W    = ODD_W + DIG_W;
  localparam int RCP_W      = 28;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 3'd0,
    CMD_START  = 3'd1,
    CMD_SET    = 3'd2,
    CMD_GET    = 3'd3,
    CMD_PAUSE  = 3'd4,
    CMD_RESUME = 3'd5,
    CMD_CLOSE  = 3'd6
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_EXPIRED = 2'd0,
    KIND_READ    = 2'd1,
    KIND_ACK     = 2'd2
  } kind_t;

  typedef enum logic [UNIT_W-1:0] {
    UNIT_TENTHS  = 2'd0,
    UNIT_SECONDS = 2'd1,
    UNIT_MINUTES = 2'd2,
    UNIT_MILLIS  = 2'd3
  } unit_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT,
    ST_DGO,
    ST_DIV,
    ST_FIN,
    ST_LAST
  } state_t;

  typedef struct packed {
    logic [MS_W-1:0]   rem;
    logic [MS_W-1:0]   tot;
    logic              run;
    logic              pau;
    logic [UNIT_W-1:0] unit;
  } timer_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  timer;
    logic [VAL_W-1:0]  value;
  } result_t;

  typedef struct packed {
    logic              go;
    logic [MS_W-1:0]   dividend;
    logic [UNIT_W-1:0] unit;
  } div_req_t;

  function automatic logic [SCALE_W-1:0] unit_scale(input logic [UNIT_W-1:0] u);
    logic [SCALE_W-1:0] s;
    unique case (unit_t'(u))
      UNIT_TENTHS:  s = SCALE_W'(100);
      UNIT_SECONDS: s = SCALE_W'(1000);
      UNIT_MINUTES: s = SCALE_W'(60000);
      UNIT_MILLIS:  s = SCALE_W'(1);
      default:      s = SCALE_W'(1);
    endcase
    return s;
  endfunction

endpackage

### sv/etb_cell.sv
// ----------------------------------------------------------------------------
// etb_cell: one timer slot of the rotating ring
// Holds the state of one timer and takes its neighbour's state on a shift;
// a bank-wide clear stops the timer but keeps its unit.
// ----------------------------------------------------------------------------
module etb_cell
  import etb_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   shift,
  input  logic   clear,
  input  timer_t d,
  output timer_t q
);

  timer_t q_r, q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (clear) begin
      q_nxt      = '0;
      q_nxt.unit = q_r.unit;
    end else if (shift) begin
      q_nxt = d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

### sv/etb_div.sv
// ----------------------------------------------------------------------------
// etb_div: divider for remaining-time reads
// Divides a millisecond count by the unit scale: drop the power-of-two factor
// of the scale, then run long division by the odd part in 16-bit digits, each
// quotient digit found by reciprocal multiplication; done pulses with the
// quotient settled.
// ----------------------------------------------------------------------------
module etb_div
  import etb_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  div_req_t        req,
  output logic            done,
  output logic [MS_W-1:0] quot
);

  localparam int PROD_W = TRIAL_W + RCP_W;

  logic [MS_W-1:0]      num_r, num_nxt;
  logic [MS_W-1:0]      quot_r, quot_nxt;
  logic [ODD_W-1:0]     rem_r, rem_nxt;
  logic [TRIAL_W-1:0]   trial_r, trial_nxt;
  logic [DIG_W-1:0]     qd_r, qd_nxt;
  logic [UNIT_W-1:0]    unit_r, unit_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 act_r, act_nxt;
  logic                 ph_r, ph_nxt;
  logic                 done_r, done_nxt;
  logic [TRIAL_W-1:0]   trial;
  logic [RCP_W-1:0]     rcp;
  logic [ODD_W-1:0]     odd;
  logic [PROD_W-1:0]    prod;
  logic [DIG_W-1:0]     qd;
  logic [TRIAL_W-1:0]   back;

  always_comb begin
    // reciprocal rounded up, exact for any trial below 2^TRIAL_W
    unique case (unit_t'(unit_r))
      UNIT_TENTHS: begin
        rcp = RCP_W'(171798692);
        odd = ODD_W'(25);
      end
      UNIT_SECONDS: begin
        rcp = RCP_W'(137438954);
        odd = ODD_W'(125);
      end
      UNIT_MINUTES: begin
        rcp = RCP_W'(146601551);
        odd = ODD_W'(1875);
      end
      default: begin
        rcp = RCP_W'(134217728);
        odd = ODD_W'(1);
      end
    endcase

    trial = {rem_r, num_r[MS_W-1 -: DIG_W]};
    prod  = PROD_W'(trial) * PROD_W'(rcp);
    unique case (unit_t'(unit_r))
      UNIT_TENTHS:  qd = prod[32 +: DIG_W];
      UNIT_SECONDS: qd = prod[34 +: DIG_W];
      UNIT_MINUTES: qd = prod[38 +: DIG_W];
      default:      qd = prod[27 +: DIG_W];
    endcase
    back = TRIAL_W'(qd_r) * TRIAL_W'(odd);
  end

  always_comb begin
    num_nxt   = num_r;
    quot_nxt  = quot_r;
    rem_nxt   = rem_r;
    trial_nxt = trial_r;
    qd_nxt    = qd_r;
    unit_nxt  = unit_r;
    cnt_nxt   = cnt_r;
    act_nxt   = act_r;
    ph_nxt    = ph_r;
    done_nxt  = 1'b0;
    if (req.go) begin
      // strip the power-of-two factor of the scale
      unique case (unit_t'(req.unit))
        UNIT_TENTHS:  num_nxt = req.dividend >> 2;
        UNIT_SECONDS: num_nxt = req.dividend >> 3;
        UNIT_MINUTES: num_nxt = req.dividend >> 5;
        default:      num_nxt = req.dividend;
      endcase
      quot_nxt = '0;
      rem_nxt  = '0;
      unit_nxt = req.unit;
      cnt_nxt  = DIV_CNT_W'(DIV_DIGITS);
      act_nxt  = 1'b1;
      ph_nxt   = 1'b0;
    end else if (act_r) begin
      if (!ph_r) begin
        qd_nxt    = qd;
        trial_nxt = trial;
        num_nxt   = {num_r[MS_W-DIG_W-1:0], {DIG_W{1'b0}}};
        ph_nxt    = 1'b1;
      end else begin
        // remainder stays below the odd divisor
        rem_nxt  = ODD_W'(trial_r - back);
        quot_nxt = {quot_r[MS_W-DIG_W-1:0], qd_r};
        cnt_nxt  = cnt_r - 1'b1;
        ph_nxt   = 1'b0;
        if (cnt_r == DIV_CNT_W'(1)) begin
          act_nxt  = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      ph_r   <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      unit_r <= '0;
    end else begin
      act_r  <= act_nxt;
      ph_r   <= ph_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      unit_r <= unit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r   <= num_nxt;
    quot_r  <= quot_nxt;
    rem_r   <= rem_nxt;
    trial_r <= trial_nxt;
    qd_r    <= qd_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

### sv/event_timer_bank.sv
// ----------------------------------------------------------------------------
// event_timer_bank: bank of one-shot millisecond timers
// Timer states circulate through a ring of cells past one shared update unit.
// ----------------------------------------------------------------------------
// Usage:
//   A command is taken at a clock edge with start high and busy low. Drive
//   a tick once per millisecond; start, set, get, pause and resume address
//   a timer by in_timer_index, while close stops every timer.
//   Each command turns the ring once past the update unit, which holds the
//   ring for a multiply when start or set reaches a valid index. A get then
//   divides the remaining time by the unit scale in 16-bit digits. A start
//   or set that expires its timer gives an expired result ahead of its
//   acknowledge. Results appear on the out_ ports the cycle after they are
//   formed, each marked by out_strobe for a single cycle; out_last flags
//   the final result of a command.
//   The receiver cannot stall: every strobed result counts as a transfer.
//   Reset stops every timer and clears all counts and units; a command can
//   be taken at the first edge with rst_n high.
// ----------------------------------------------------------------------------
module event_timer_bank
  import etb_pkg::*;
#(
  parameter int TIMER_COUNT = TIMER_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [IDX_W-1:0]  in_timer_index,
  input  logic [VAL_W-1:0]  in_time_value,
  input  logic [UNIT_W-1:0] in_time_unit,
  output logic              out_strobe,
  output logic [KIND_W-1:0] out_result_kind,
  output logic [IDX_W-1:0]  out_result_timer,
  output logic [VAL_W-1:0]  out_read_value,
  output logic              out_last
);

  localparam int POS_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int CMP_W = (POS_W > IDX_W) ? POS_W : IDX_W;

  // ring of cells; cell 0 is the head seen by the update unit
  timer_t cell_q [TIMER_COUNT];
  timer_t cell_d [TIMER_COUNT];
  timer_t head, head_nxt;
  logic   shift, clear_all;

  for (genvar k = 0; k < TIMER_COUNT; k++) begin : g_ring
    if (k == TIMER_COUNT - 1) begin : g_tail
      assign cell_d[k] = head_nxt;
    end else begin : g_link
      assign cell_d[k] = cell_q[k+1];
    end
    etb_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (shift),
      .clear (clear_all),
      .d     (cell_d[k]),
      .q     (cell_q[k])
    );
  end

  assign head = cell_q[0];

  div_req_t        div_req;
  logic            div_done;
  logic [MS_W-1:0] div_quot;

  etb_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .done (div_done),
    .quot (div_quot)
  );

  state_t            state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [VAL_W-1:0]  tv_r, tv_nxt;
  logic [UNIT_W-1:0] tu_r, tu_nxt;
  logic              ok_r, ok_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              mul_done_r, mul_done_nxt;
  logic [MS_W-1:0]   prod_r, prod_nxt;
  logic [MS_W-1:0]   elapsed_r, elapsed_nxt;
  logic [MS_W-1:0]   get_rem_r, get_rem_nxt;
  logic [UNIT_W-1:0] get_unit_r, get_unit_nxt;
  logic              pend_v_r, pend_v_nxt;
  result_t           pend_r, pend_nxt;
  logic              out_strobe_r, out_strobe_nxt;
  result_t           out_res_r, out_res_nxt;
  logic              out_last_r, out_last_nxt;

  logic              match;
  logic              expire;
  logic              fin_has;
  result_t           fin_res;
  logic [MS_W-1:0]   dec;
  logic [SCALE_W-1:0] sc;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    idx_nxt        = idx_r;
    tv_nxt         = tv_r;
    tu_nxt         = tu_r;
    ok_nxt         = ok_r;
    pos_nxt        = pos_r;
    mul_done_nxt   = mul_done_r;
    prod_nxt       = prod_r;
    elapsed_nxt    = elapsed_r;
    get_rem_nxt    = get_rem_r;
    get_unit_nxt   = get_unit_r;
    pend_v_nxt     = pend_v_r;
    pend_nxt       = pend_r;
    out_strobe_nxt = 1'b0;
    out_res_nxt    = out_res_r;
    out_last_nxt   = 1'b0;
    shift          = 1'b0;
    clear_all      = 1'b0;
    head_nxt       = head;
    div_req        = '0;
    expire         = 1'b0;
    dec            = head.rem - 1'b1;
    match          = ok_r && (CMP_W'(pos_r) == CMP_W'(idx_r));
    sc             = unit_scale((cmd_r == CMD_START) ? tu_r : head.unit);
    fin_has        = 1'b1;
    fin_res        = '{kind: KIND_ACK, timer: idx_r, value: '0};

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt      = cmd_t'(in_command);
          idx_nxt      = in_timer_index;
          tv_nxt       = in_time_value;
          tu_nxt       = in_time_unit;
          ok_nxt       = (32'(in_timer_index) < TIMER_COUNT);
          pos_nxt      = '0;
          mul_done_nxt = 1'b0;
          get_rem_nxt  = '0;
          get_unit_nxt = '0;
          clear_all    = (cmd_t'(in_command) == CMD_CLOSE);
          state_nxt    = ST_ROT;
        end
      end

      ST_ROT: begin
        if (match && (cmd_r == CMD_START || cmd_r == CMD_SET) && !mul_done_r) begin
          // hold the ring while the new total is formed
          prod_nxt     = MS_W'(tv_r) * MS_W'(sc);
          elapsed_nxt  = (head.tot >= head.rem) ? head.tot - head.rem : '0;
          mul_done_nxt = 1'b1;
        end else begin
          shift = 1'b1;
          unique case (cmd_r)
            CMD_TICK: begin
              if (head.run && !head.pau) begin
                if (dec == '0) begin
                  expire = 1'b1;
                end else begin
                  head_nxt.rem = dec;
                end
              end
            end
            CMD_START: begin
              if (match) begin
                head_nxt.unit = tu_r;
                head_nxt.pau  = 1'b0;
                if (prod_r == '0) begin
                  expire = 1'b1;
                end else begin
                  head_nxt.run = 1'b1;
                  head_nxt.tot = prod_r;
                  head_nxt.rem = prod_r;
                end
              end
            end
            CMD_SET: begin
              if (match && head.run) begin
                head_nxt.pau = 1'b0;
                if (prod_r <= elapsed_r) begin
                  expire = 1'b1;
                end else begin
                  head_nxt.tot = prod_r;
                  head_nxt.rem = prod_r - elapsed_r;
                end
              end
            end
            CMD_GET: begin
              if (match && head.run) begin
                get_rem_nxt  = head.rem;
                get_unit_nxt = head.unit;
              end
            end
            CMD_PAUSE: begin
              if (match && head.run) begin
                head_nxt.pau = 1'b1;
              end
            end
            CMD_RESUME: begin
              if (match && head.run) begin
                head_nxt.pau = 1'b0;
              end
            end
            default: begin
            end
          endcase

          if (expire) begin
            // stop the timer, keep its unit
            head_nxt.run = 1'b0;
            head_nxt.pau = 1'b0;
            head_nxt.rem = '0;
            head_nxt.tot = '0;
            if (pend_v_r) begin
              out_strobe_nxt = 1'b1;
              out_res_nxt    = pend_r;
            end
            pend_v_nxt = 1'b1;
            pend_nxt   = '{kind: KIND_EXPIRED, timer: IDX_W'(pos_r), value: '0};
          end

          if (pos_r == POS_W'(TIMER_COUNT - 1)) begin
            pos_nxt   = '0;
            state_nxt = (cmd_r == CMD_GET) ? ST_DGO : ST_FIN;
          end else begin
            pos_nxt = pos_r + 1'b1;
          end
        end
      end

      ST_DGO: begin
        div_req.go       = 1'b1;
        div_req.dividend = get_rem_r;
        div_req.unit     = get_unit_r;
        state_nxt        = ST_DIV;
      end

      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_FIN;
        end
      end

      ST_FIN: begin
        unique case (cmd_r)
          CMD_TICK:  fin_has = 1'b0;
          CMD_CLOSE: fin_res.timer = '0;
          CMD_GET: begin
            fin_res.kind  = KIND_READ;
            fin_res.value = div_quot[VAL_W-1:0];
          end
          CMD_START, CMD_SET, CMD_PAUSE, CMD_RESUME: begin
          end
          default:   fin_has = 1'b0;
        endcase
        // the held result goes first; the command's own result, if any, closes the list
        if (fin_has) begin
          out_strobe_nxt = 1'b1;
          if (pend_v_r) begin
            out_res_nxt = pend_r;
            pend_nxt    = fin_res;
            state_nxt   = ST_LAST;
          end else begin
            out_res_nxt  = fin_res;
            out_last_nxt = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end else begin
          if (pend_v_r) begin
            out_strobe_nxt = 1'b1;
            out_res_nxt    = pend_r;
            out_last_nxt   = 1'b1;
            pend_v_nxt     = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end

      ST_LAST: begin
        out_strobe_nxt = 1'b1;
        out_res_nxt    = pend_r;
        out_last_nxt   = 1'b1;
        pend_v_nxt     = 1'b0;
        state_nxt      = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pos_r        <= '0;
      mul_done_r   <= 1'b0;
      pend_v_r     <= 1'b0;
      out_strobe_r <= 1'b0;
      out_last_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pos_r        <= pos_nxt;
      mul_done_r   <= mul_done_nxt;
      pend_v_r     <= pend_v_nxt;
      out_strobe_r <= out_strobe_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    idx_r      <= idx_nxt;
    tv_r       <= tv_nxt;
    tu_r       <= tu_nxt;
    ok_r       <= ok_nxt;
    prod_r     <= prod_nxt;
    elapsed_r  <= elapsed_nxt;
    get_rem_r  <= get_rem_nxt;
    get_unit_r <= get_unit_nxt;
    pend_r     <= pend_nxt;
    out_res_r  <= out_res_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_strobe       = out_strobe_r;
  assign out_result_kind  = out_res_r.kind;
  assign out_result_timer = out_res_r.timer;
  assign out_read_value   = out_res_r.value;
  assign out_last         = out_last_r;

endmodule

### verif/event_timer_bank_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_timer_bank_tb: self-checking bench for the event timer bank
// Drives ticks and timer commands through the start/busy handshake with
// random sender gaps. A scoreboard class keeps its own copy of every timer.
// Each accepted command updates that copy and queues the expected results.
// Every strobed result is then checked field by field against the queue.
// ----------------------------------------------------------------------------
module event_timer_bank_tb;
  import etb_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam logic [63:0]      MS_MASK    = 64'hFFFF_FFFF_FFFF;
  localparam int ITEMS_TARGET   = 380;
  localparam int SETTLE_CYCLES  = TIMER_COUNT_DEF + 60;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    kind_t             kind;
    logic [IDX_W-1:0]  timer;
    logic [VAL_W-1:0]  value;
    logic              last;
  } outcome_t;

  class timer_bank_scoreboard;
    logic [MS_W-1:0] left_ms [TIMER_COUNT_DEF];
    logic [MS_W-1:0] span_ms [TIMER_COUNT_DEF];
    bit              armed [TIMER_COUNT_DEF];
    bit              held [TIMER_COUNT_DEF];
    unit_t           base_unit [TIMER_COUNT_DEF];
    outcome_t        due [$];
    int              errors;

    function new();
      for (int k = 0; k < TIMER_COUNT_DEF; k++) begin
        disarm(k);
        base_unit[k] = UNIT_TENTHS;
      end
      errors = 0;
    endfunction

    function void disarm(int k);
      armed[k]   = 1'b0;
      held[k]    = 1'b0;
      left_ms[k] = '0;
      span_ms[k] = '0;
    endfunction

    function logic [63:0] ms_per_unit(logic [UNIT_W-1:0] u);
      case (u)
        UNIT_TENTHS:  return 64'd100;
        UNIT_SECONDS: return 64'd1000;
        UNIT_MINUTES: return 64'd60000;
        default:      return 64'd1;
      endcase
    endfunction

    function void post(kind_t kind, logic [IDX_W-1:0] timer, logic [VAL_W-1:0] value);
      outcome_t o;
      o.kind  = kind;
      o.timer = timer;
      o.value = value;
      o.last  = 1'b0;
      due.push_back(o);
    endfunction

    // update the timer copy for one accepted command and queue its results
    function void apply_command(logic [CMD_W-1:0] c, logic [IDX_W-1:0] idx,
                                logic [VAL_W-1:0] tv, logic [UNIT_W-1:0] tu);
      logic [63:0] ms;
      logic [63:0] elapsed;
      logic [63:0] quot;
      int          queued;
      outcome_t    tail;
      queued = due.size();
      case (c)
        CMD_TICK: begin
          for (int k = 0; k < TIMER_COUNT_DEF; k++) begin
            if (armed[k] && !held[k]) begin
              left_ms[k] = left_ms[k] - 1'b1;
              if (left_ms[k] == '0) begin
                disarm(k);
                post(KIND_EXPIRED, IDX_W'(k), '0);
              end
            end
          end
        end
        CMD_START: begin
          ms = (64'(tv) * ms_per_unit(tu)) & MS_MASK;
          base_unit[idx] = unit_t'(tu);
          held[idx] = 1'b0;
          if (ms == 0) begin
            disarm(idx);
            post(KIND_EXPIRED, idx, '0);
          end else begin
            armed[idx]   = 1'b1;
            span_ms[idx] = ms[MS_W-1:0];
            left_ms[idx] = ms[MS_W-1:0];
          end
          post(KIND_ACK, idx, '0);
        end
        CMD_SET: begin
          if (armed[idx]) begin
            ms = (64'(tv) * ms_per_unit(base_unit[idx])) & MS_MASK;
            elapsed = (span_ms[idx] >= left_ms[idx]) ?
                      64'(span_ms[idx] - left_ms[idx]) : 64'd0;
            held[idx] = 1'b0;
            if (ms <= elapsed) begin
              disarm(idx);
              post(KIND_EXPIRED, idx, '0);
            end else begin
              span_ms[idx] = ms[MS_W-1:0];
              left_ms[idx] = 48'(ms - elapsed);
            end
          end
          post(KIND_ACK, idx, '0);
        end
        CMD_GET: begin
          quot = armed[idx] ? 64'(left_ms[idx]) / ms_per_unit(base_unit[idx]) : 64'd0;
          post(KIND_READ, idx, quot[VAL_W-1:0]);
        end
        CMD_PAUSE: begin
          if (armed[idx])
            held[idx] = 1'b1;
          post(KIND_ACK, idx, '0);
        end
        CMD_RESUME: begin
          if (armed[idx])
            held[idx] = 1'b0;
          post(KIND_ACK, idx, '0);
        end
        CMD_CLOSE: begin
          for (int k = 0; k < TIMER_COUNT_DEF; k++)
            disarm(k);
          post(KIND_ACK, '0, '0);
        end
        default: ;
      endcase
      // flag the final result of this command
      if (due.size() > queued) begin
        tail = due.pop_back();
        tail.last = 1'b1;
        due.push_back(tail);
      end
    endfunction

    function void check_field(string what, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        errors++;
      end
    endfunction

    function void match_result(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] timer,
                               logic [VAL_W-1:0] value, logic last);
      outcome_t want;
      if (due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got kind %0d timer %0d value %0d",
                 $time, kind, timer, value);
        errors++;
        return;
      end
      want = due.pop_front();
      check_field("result_kind", VAL_W'(want.kind), VAL_W'(kind));
      check_field("result_timer", VAL_W'(want.timer), VAL_W'(timer));
      check_field("read_value", want.value, value);
      check_field("last", VAL_W'(want.last), VAL_W'(last));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [CMD_W-1:0]  in_command = '0;
  logic [IDX_W-1:0]  in_timer_index = '0;
  logic [VAL_W-1:0]  in_time_value = '0;
  logic [UNIT_W-1:0] in_time_unit = '0;
  logic              out_strobe;
  logic [KIND_W-1:0] out_result_kind;
  logic [IDX_W-1:0]  out_result_timer;
  logic [VAL_W-1:0]  out_read_value;
  logic              out_last;

  timer_bank_scoreboard sb = new();
  int items_sent = 0;
  int quiet_left = 0;
  bit quiet = 1'b0;
  int idle_cycles = 0;

  event_timer_bank DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_timer_index   (in_timer_index),
    .in_time_value    (in_time_value),
    .in_time_unit     (in_time_unit),
    .out_strobe       (out_strobe),
    .out_result_kind  (out_result_kind),
    .out_result_timer (out_result_timer),
    .out_read_value   (out_read_value),
    .out_last         (out_last)
  );

  always #5 clk = ~clk;

  // note transfers on both sides and watch for a stalled bank
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe === 1'b1)
        sb.match_result(out_result_kind, out_result_timer, out_read_value, out_last);
      if (start && busy === 1'b0)
        sb.apply_command(in_command, in_timer_index, in_time_value, in_time_unit);
      if (out_strobe === 1'b1 || (start && busy === 1'b0)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  task automatic issue(input logic [CMD_W-1:0] c, input logic [IDX_W-1:0] idx,
                       input logic [VAL_W-1:0] tv, input logic [UNIT_W-1:0] tu);
    int gap;
    // run stretches without gaps or stretches of random gaps, picked at random
    if (quiet_left == 0) begin
      quiet = ($urandom_range(0, 2) == 0);
      quiet_left = $urandom_range(20, 40);
    end
    quiet_left--;
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_command     <= c;
    in_timer_index <= idx;
    in_time_value  <= tv;
    in_time_unit   <= tu;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    if (c != CMD_UNUSED)
      items_sent++;
  endtask

  // hold the sender off until every queued result has arrived
  task automatic await_quiet_bank();
    start <= 1'b0;
    @(posedge clk);
    while (sb.due.size() != 0) @(posedge clk);
  endtask

  initial begin
    int               sel;
    int               burst_ms;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] tv;
    logic [UNIT_W-1:0] tu;
    bit               drained;
    drained = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle read, zero-time start, largest values in tenths, minutes and seconds
    issue(CMD_GET, 3'd0, '0, UNIT_TENTHS);
    issue(CMD_START, 3'd0, '0, UNIT_MILLIS);
    issue(CMD_START, 3'd1, '1, UNIT_TENTHS);
    issue(CMD_START, 3'd2, '1, UNIT_MINUTES);
    issue(CMD_START, 3'd3, '1, UNIT_SECONDS);
    issue(CMD_GET, 3'd1, '0, UNIT_MILLIS);
    issue(CMD_GET, 3'd2, '0, UNIT_MILLIS);
    issue(CMD_GET, 3'd3, '0, UNIT_MILLIS);
    // several expiries on one tick while a paused timer stays frozen
    issue(CMD_START, 3'd4, 32'd2, UNIT_MILLIS);
    issue(CMD_START, 3'd5, 32'd2, UNIT_MILLIS);
    issue(CMD_START, 3'd6, 32'd3, UNIT_MILLIS);
    issue(CMD_START, 3'd7, 32'd2, UNIT_MILLIS);
    issue(CMD_PAUSE, 3'd6, '0, UNIT_MILLIS);
    issue(CMD_TICK, 3'd0, '0, UNIT_MILLIS);
    issue(CMD_TICK, 3'd0, '0, UNIT_MILLIS);
    issue(CMD_GET, 3'd6, '0, UNIT_MILLIS);
    issue(CMD_RESUME, 3'd6, '0, UNIT_MILLIS);
    issue(CMD_PAUSE, 3'd4, '0, UNIT_MILLIS);
    issue(CMD_RESUME, 3'd6, '0, UNIT_MILLIS);
    // set at or below the elapsed time expires at once; set on an idle timer only acks
    issue(CMD_SET, 3'd6, '0, UNIT_MILLIS);
    issue(CMD_SET, 3'd6, 32'd5, UNIT_MILLIS);
    issue(CMD_SET, 3'd1, 32'd1, UNIT_SECONDS);
    issue(CMD_GET, 3'd1, '0, UNIT_MILLIS);
    issue(CMD_UNUSED, 3'd7, '1, UNIT_MILLIS);
    issue(CMD_CLOSE, 3'd5, '0, UNIT_MILLIS);

    while (items_sent < ITEMS_TARGET) begin
      if (!drained && items_sent >= ITEMS_TARGET / 2) begin
        await_quiet_bank();
        drained = 1'b1;
      end
      if ($urandom_range(0, 99) < 8) begin
        // arm every timer alike, then tick them all out together
        burst_ms = $urandom_range(1, 4);
        for (int k = 0; k < TIMER_COUNT_DEF; k++)
          issue(CMD_START, IDX_W'(k), VAL_W'(burst_ms), UNIT_MILLIS);
        repeat (burst_ms) issue(CMD_TICK, IDX_W'($urandom_range(0, 7)), $urandom(),
                                UNIT_W'($urandom_range(0, 3)));
      end else begin
        sel = $urandom_range(0, 99);
        idx = IDX_W'($urandom_range(0, 7));
        tu  = UNIT_W'($urandom_range(0, 3));
        case ($urandom_range(0, 9))
          0:       tv = $urandom();
          1:       tv = '0;
          default: tv = $urandom_range(1, 40);
        endcase
        if (sel < 45) begin
          issue(CMD_TICK, idx, tv, tu);
        end else if (sel < 62) begin
          if ($urandom_range(0, 9) < 7)
            tu = UNIT_MILLIS;
          issue(CMD_START, idx, tv, tu);
        end else if (sel < 72) begin
          issue(CMD_SET, idx, tv, tu);
        end else if (sel < 82) begin
          issue(CMD_GET, idx, tv, tu);
        end else if (sel < 89) begin
          issue(CMD_PAUSE, idx, tv, tu);
        end else if (sel < 96) begin
          issue(CMD_RESUME, idx, tv, tu);
        end else if (sel < 98) begin
          issue(CMD_CLOSE, idx, tv, tu);
        end else begin
          issue(CMD_UNUSED, idx, tv, tu);
        end
      end
    end

    await_quiet_bank();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
